// ===== src/dhu_pkg.sv =====
// Shared types, constants and stage counts of the depth-hole unprojector.
// Used by every module under src; depends on nothing.
package dhu_pkg;

	localparam int DEPTH_BITS_DEF = 24;
	localparam int COORD_BITS_DEF = 12;

	localparam logic [31:0] EMPTY_ID = 32'hFFFF_FFFF;

	// configuration: eight 64-bit words, two Q16.16 coefficients each
	localparam int NUM_PAIRS    = 8;
	localparam int CFG_IDX_BITS = 4;
	localparam logic [63:0] PAIR_RESET [NUM_PAIRS] = '{
		64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
		64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
	};

	localparam int FRAC_BITS = 16;

	// mean depth divider: 16 quotient bits, four per stage
	localparam int ZBITS      = 16;
	localparam int MEAN_STEPS = 4;
	localparam int MEAN_ST    = 2 + ZBITS / MEAN_STEPS;

	// matrix multiply: products, then row sums
	localparam int XF_ST = 2;

	// position divider: 32 quotient bits, four per stage
	localparam int QBITS     = 32;
	localparam int DIV_STEPS = 4;
	localparam int DIV_ST    = 3 + QBITS / DIV_STEPS;

	localparam int NUM_ST = MEAN_ST + XF_ST + DIV_ST;

	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] POS_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SEEN   = 2'd1,
		KIND_REGION = 2'd2
	} kind_t;

	// side information of one divider lane
	typedef struct packed {
		logic neg;
		logic acc_pos;
		logic acc_neg;
		logic w_zero;
		logic ovf;
	} div_flags_t;

endpackage

// ===== src/dhu_mean.sv =====
// Mean of the near depths in a 3x3 window: sum and count, then a
// pipelined restoring divider. Depends on dhu_pkg.
module dhu_mean #(
	parameter int DEPTH_BITS = dhu_pkg::DEPTH_BITS_DEF,
	parameter int COORD_BITS = dhu_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic [dhu_pkg::MEAN_ST-1:0]     en,
	input  logic [8:0][DEPTH_BITS-1:0]      depth,
	input  logic [COORD_BITS-1:0]           x_in,
	input  logic [COORD_BITS-1:0]           y_in,
	output logic                            many,
	output logic [dhu_pkg::ZBITS-1:0]       z,
	output logic [COORD_BITS-1:0]           x_out,
	output logic [COORD_BITS-1:0]           y_out
);
	import dhu_pkg::*;

	localparam int SW  = DEPTH_BITS + 4;
	localparam int NDS = ZBITS / MEAN_STEPS;
	localparam logic [DEPTH_BITS-1:0] FAR = '1;

	logic [SW-1:0]         sum_c;
	logic [3:0]            cnt_c;
	logic [SW-1:0]         sum_s1;
	logic [3:0]            cnt_s1;
	logic [SW-1:0]         rem_s2;
	logic [SW-1:0]         den_s2;
	logic [SW-1:0]         rem_sd [NDS-1];
	logic [SW-1:0]         den_sd [NDS-1];
	logic [ZBITS-1:0]      q_sd [NDS];
	logic [COORD_BITS-1:0] x_sp [MEAN_ST];
	logic [COORD_BITS-1:0] y_sp [MEAN_ST];

	// sum and count the depths that are not far
	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < 9; i++) begin
			if (depth[i] != FAR) begin
				sum_c = sum_c + SW'(depth[i]);
				cnt_c = cnt_c + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sum_s1 <= sum_c;
			cnt_s1 <= cnt_c;
		end
	end

	assign many = (cnt_s1 >= 4'd2);

	// divisor is count * far; the remainder starts as the sum
	always_ff @(posedge clk) begin
		if (en[1]) begin
			rem_s2 <= sum_s1;
			den_s2 <= (SW'(cnt_s1) << DEPTH_BITS) - SW'(cnt_s1);
		end
	end

	// carry the pixel coordinates alongside
	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_sp[0] <= x_in;
			y_sp[0] <= y_in;
		end
	end

	for (genvar k = 1; k < MEAN_ST; k++) begin : g_coord
		always_ff @(posedge clk) begin
			if (en[k]) begin
				x_sp[k] <= x_sp[k-1];
				y_sp[k] <= y_sp[k-1];
			end
		end
	end

	// four quotient bits per stage
	for (genvar k = 0; k < NDS; k++) begin : g_step
		logic [SW-1:0]    rem_i;
		logic [SW-1:0]    den_i;
		logic [ZBITS-1:0] q_i;
		logic [SW-1:0]    rem_n;
		logic [ZBITS-1:0] q_n;
		logic [SW:0]      t;

		if (k == 0) begin : g_first
			assign rem_i = rem_s2;
			assign den_i = den_s2;
			assign q_i   = '0;
		end else begin : g_next
			assign rem_i = rem_sd[k-1];
			assign den_i = den_sd[k-1];
			assign q_i   = q_sd[k-1];
		end

		always_comb begin
			rem_n = rem_i;
			q_n   = q_i;
			t     = '0;
			for (int j = 0; j < MEAN_STEPS; j++) begin
				t = {rem_n, 1'b0};
				if (t >= {1'b0, den_i}) begin
					t   = t - {1'b0, den_i};
					q_n = {q_n[ZBITS-2:0], 1'b1};
				end else begin
					q_n = {q_n[ZBITS-2:0], 1'b0};
				end
				rem_n = t[SW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[2+k]) begin
				q_sd[k] <= q_n;
			end
		end

		if (k < NDS - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en[2+k]) begin
					rem_sd[k] <= rem_n;
					den_sd[k] <= den_i;
				end
			end
		end
	end

	assign z     = q_sd[NDS-1];
	assign x_out = x_sp[MEAN_ST-1];
	assign y_out = y_sp[MEAN_ST-1];

endmodule

// ===== src/dhu_xform.sv =====
// Row products of the 4x4 Q16.16 matrix with (x, y, z, 1), then row sums.
// Depends on dhu_pkg.
module dhu_xform #(
	parameter int COORD_BITS = dhu_pkg::COORD_BITS_DEF,
	parameter int ACC_BITS   = dhu_pkg::COORD_BITS_DEF + 35
) (
	input  logic                                   clk,
	input  logic [dhu_pkg::XF_ST-1:0]              en,
	input  logic [dhu_pkg::NUM_PAIRS-1:0][63:0]    mat,
	input  logic [dhu_pkg::ZBITS-1:0]              z,
	input  logic [COORD_BITS-1:0]                  x,
	input  logic [COORD_BITS-1:0]                  y,
	output logic signed [ACC_BITS-1:0]             acc [4]
);
	import dhu_pkg::*;

	localparam int PW0 = COORD_BITS + 33;
	localparam int PW2 = 32 + ZBITS + 1;

	logic signed [PW0-1:0]      px_s1 [4];
	logic signed [PW0-1:0]      py_s1 [4];
	logic signed [PW2-1:0]      pz_s1 [4];
	logic signed [31:0]         c3_s1 [4];
	logic signed [ACC_BITS-1:0] acc_s2 [4];

	// one product per coefficient
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int r = 0; r < 4; r++) begin
				px_s1[r] <= $signed(mat[2*r][31:0]) * $signed({1'b0, x});
				py_s1[r] <= $signed(mat[2*r][63:32]) * $signed({1'b0, y});
				pz_s1[r] <= $signed(mat[2*r+1][31:0]) * $signed({1'b0, z});
				c3_s1[r] <= $signed(mat[2*r+1][63:32]);
			end
		end
	end

	// sum each row; the depth term is floored back to Q16.16
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 4; r++) begin
				acc_s2[r] <= ACC_BITS'(px_s1[r]) + ACC_BITS'(py_s1[r])
					+ ACC_BITS'(pz_s1[r] >>> FRAC_BITS) + ACC_BITS'(c3_s1[r]);
			end
		end
	end

	assign acc = acc_s2;

endmodule

// ===== src/dhu_div.sv =====
// One lane of the position divider: acc / w in Q16.16, truncated toward
// zero and saturated. Pipelined restoring division. Depends on dhu_pkg.
module dhu_div #(
	parameter int ACC_BITS = dhu_pkg::COORD_BITS_DEF + 35
) (
	input  logic                          clk,
	input  logic [dhu_pkg::DIV_ST-1:0]    en,
	input  logic signed [ACC_BITS-1:0]    acc,
	input  logic signed [ACC_BITS-1:0]    w,
	output logic [31:0]                   pos
);
	import dhu_pkg::*;

	localparam int NDS = QBITS / DIV_STEPS;

	div_flags_t          fl_s1;
	logic [ACC_BITS-1:0] n_s1;
	logic [ACC_BITS-1:0] d_s1;
	div_flags_t          fl_s2;
	logic [ACC_BITS-1:0] rem_s2;
	logic [ACC_BITS-1:0] d_s2;
	logic [QBITS-1:0]    bits_s2;
	logic [ACC_BITS-1:0] rem_sd [NDS-1];
	logic [ACC_BITS-1:0] d_sd [NDS-1];
	logic [QBITS-1:0]    bits_sd [NDS-1];
	logic [QBITS-1:0]    q_sd [NDS];
	div_flags_t          fl_sd [NDS];
	logic [32:0]         mag;
	logic [32:0]         mag_neg;
	logic [31:0]         res;
	logic [31:0]         pos_so;

	// take magnitudes and signs
	always_ff @(posedge clk) begin
		if (en[0]) begin
			fl_s1.neg     <= acc[ACC_BITS-1] ^ w[ACC_BITS-1];
			fl_s1.acc_pos <= !acc[ACC_BITS-1] && (acc != '0);
			fl_s1.acc_neg <= acc[ACC_BITS-1];
			fl_s1.w_zero  <= (w == '0);
			fl_s1.ovf     <= 1'b0;
			n_s1 <= acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
			d_s1 <= w[ACC_BITS-1] ? ACC_BITS'(-w) : ACC_BITS'(w);
		end
	end

	// flag an integer part of 2^16 or more; seed the remainder
	always_ff @(posedge clk) begin
		if (en[1]) begin
			fl_s2.neg     <= fl_s1.neg;
			fl_s2.acc_pos <= fl_s1.acc_pos;
			fl_s2.acc_neg <= fl_s1.acc_neg;
			fl_s2.w_zero  <= fl_s1.w_zero;
			fl_s2.ovf     <= fl_s1.ovf ||
				({{FRAC_BITS{1'b0}}, n_s1} >= {d_s1, {FRAC_BITS{1'b0}}});
			rem_s2    <= ACC_BITS'(n_s1 >> FRAC_BITS);
			d_s2      <= d_s1;
			bits_s2   <= {n_s1[FRAC_BITS-1:0], {(QBITS-FRAC_BITS){1'b0}}};
		end
	end

	// four quotient bits per stage
	for (genvar k = 0; k < NDS; k++) begin : g_step
		logic [ACC_BITS-1:0] rem_i;
		logic [ACC_BITS-1:0] d_i;
		logic [QBITS-1:0]    bits_i;
		logic [QBITS-1:0]    q_i;
		div_flags_t          fl_i;
		logic [ACC_BITS-1:0] rem_n;
		logic [QBITS-1:0]    bits_n;
		logic [QBITS-1:0]    q_n;
		logic [ACC_BITS:0]   t;

		if (k == 0) begin : g_first
			assign rem_i  = rem_s2;
			assign d_i    = d_s2;
			assign bits_i = bits_s2;
			assign q_i    = '0;
			assign fl_i   = fl_s2;
		end else begin : g_next
			assign rem_i  = rem_sd[k-1];
			assign d_i    = d_sd[k-1];
			assign bits_i = bits_sd[k-1];
			assign q_i    = q_sd[k-1];
			assign fl_i   = fl_sd[k-1];
		end

		always_comb begin
			rem_n  = rem_i;
			bits_n = bits_i;
			q_n    = q_i;
			t      = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				t      = {rem_n, bits_n[QBITS-1]};
				bits_n = {bits_n[QBITS-2:0], 1'b0};
				if (t >= {1'b0, d_i}) begin
					t   = t - {1'b0, d_i};
					q_n = {q_n[QBITS-2:0], 1'b1};
				end else begin
					q_n = {q_n[QBITS-2:0], 1'b0};
				end
				rem_n = t[ACC_BITS-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[2+k]) begin
				q_sd[k]  <= q_n;
				fl_sd[k] <= fl_i;
			end
		end

		if (k < NDS - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en[2+k]) begin
					rem_sd[k]  <= rem_n;
					d_sd[k]    <= d_i;
					bits_sd[k] <= bits_n;
				end
			end
		end
	end

	// saturate to 32 bits; a zero divisor goes to the sign of acc
	always_comb begin
		mag     = fl_sd[NDS-1].ovf ? 33'h1_0000_0000 : {1'b0, q_sd[NDS-1]};
		mag_neg = '0;
		res     = '0;
		if (fl_sd[NDS-1].w_zero) begin
			if (fl_sd[NDS-1].acc_pos) begin
				res = POS_MAX;
			end else if (fl_sd[NDS-1].acc_neg) begin
				res = POS_MIN;
			end
		end else if (fl_sd[NDS-1].neg) begin
			if (mag > {1'b0, POS_MIN}) begin
				mag = {1'b0, POS_MIN};
			end
			mag_neg = ~mag + 33'd1;
			res     = mag_neg[31:0];
		end else begin
			if (mag > {1'b0, POS_MAX}) begin
				mag = {1'b0, POS_MAX};
			end
			res = mag[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_ST-1]) begin
			pos_so <= res;
		end
	end

	assign pos = pos_so;

endmodule

// ===== src/depth_hole_unprojector.sv =====
// Top level of the depth-hole unprojector: pixel beats in, seen points or
// world positions out. Depends on dhu_pkg, dhu_mean, dhu_xform, dhu_div.
//
//  channel   handshake               payload
//  pixel     pix_valid / pix_stall   point_id, pixel_x, pixel_y, depth_*
//  result    res_valid / res_stall   kind, seen_id, pos_x, pos_y, pos_z
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel beat per cycle while pix_stall is low; every beat passes
// through all NUM_ST stages. The pipeline depth is set by the 32-bit
// position divider (four quotient bits per stage) and the mean depth divider.
// Reset clears the valid bits and loads the identity matrix.
// A stage holds only while the stage after it is full and holding, so
// empty slots fill up under res_stall before pix_stall rises.
module depth_hole_unprojector #(
	parameter int DEPTH_BITS = dhu_pkg::DEPTH_BITS_DEF,
	parameter int COORD_BITS = dhu_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  logic [31:0]                        point_id,
	input  logic [COORD_BITS-1:0]              pixel_x,
	input  logic [COORD_BITS-1:0]              pixel_y,
	input  logic [DEPTH_BITS-1:0]              depth_nw,
	input  logic [DEPTH_BITS-1:0]              depth_n,
	input  logic [DEPTH_BITS-1:0]              depth_ne,
	input  logic [DEPTH_BITS-1:0]              depth_w,
	input  logic [DEPTH_BITS-1:0]              depth_c,
	input  logic [DEPTH_BITS-1:0]              depth_e,
	input  logic [DEPTH_BITS-1:0]              depth_sw,
	input  logic [DEPTH_BITS-1:0]              depth_s,
	input  logic [DEPTH_BITS-1:0]              depth_se,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [1:0]                         kind,
	output logic [31:0]                        seen_id,
	output logic signed [31:0]                 pos_x,
	output logic signed [31:0]                 pos_y,
	output logic signed [31:0]                 pos_z,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [dhu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [63:0]                        cfg_data
);
	import dhu_pkg::*;

	localparam int ACC_BITS = COORD_BITS + 35;
	localparam int PIDX     = $clog2(NUM_PAIRS);
	localparam int XF_LO    = MEAN_ST;
	localparam int DIV_LO   = MEAN_ST + XF_ST;

	logic [NUM_PAIRS-1:0][63:0]  mat_q;
	logic [NUM_ST-1:0]           vld_q;
	logic [NUM_ST-1:0]           en;
	logic [31:0]                 id_s1;
	kind_t                       kind_sp [1:NUM_ST-1];
	logic [31:0]                 sid_sp [1:NUM_ST-1];
	logic [8:0][DEPTH_BITS-1:0]  depth;
	logic                        many;
	logic [ZBITS-1:0]            z;
	logic [COORD_BITS-1:0]       mx;
	logic [COORD_BITS-1:0]       my;
	logic signed [ACC_BITS-1:0]  acc [4];
	logic [31:0]                 pos [3];
	logic                        region;

	// matrix registers; writes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAIRS; i++) begin
				mat_q[i] <= PAIR_RESET[i];
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_BITS'(NUM_PAIRS))) begin
			mat_q[cfg_index[PIDX-1:0]] <= cfg_data;
		end
	end

	// advance a stage when it is empty or the next one advances
	always_comb begin
		en[NUM_ST-1] = !vld_q[NUM_ST-1] || !res_stall;
		for (int k = NUM_ST - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= pix_valid;
			end
			for (int k = 1; k < NUM_ST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pix_stall = !en[0];
	assign res_valid = vld_q[NUM_ST-1];

	// decide the result kind once the count is known
	always_ff @(posedge clk) begin
		if (en[0]) begin
			id_s1 <= point_id;
		end
		if (en[1]) begin
			if (id_s1 != EMPTY_ID) begin
				kind_sp[1] <= KIND_SEEN;
				sid_sp[1]  <= id_s1;
			end else begin
				kind_sp[1] <= many ? KIND_REGION : KIND_NONE;
				sid_sp[1]  <= '0;
			end
		end
		for (int k = 2; k < NUM_ST; k++) begin
			if (en[k]) begin
				kind_sp[k] <= kind_sp[k-1];
				sid_sp[k]  <= sid_sp[k-1];
			end
		end
	end

	assign depth = {depth_nw, depth_n, depth_ne, depth_w, depth_c,
		depth_e, depth_sw, depth_s, depth_se};

	dhu_mean #(
		.DEPTH_BITS (DEPTH_BITS),
		.COORD_BITS (COORD_BITS)
	) u_mean (
		.clk   (clk),
		.en    (en[MEAN_ST-1:0]),
		.depth (depth),
		.x_in  (pixel_x),
		.y_in  (pixel_y),
		.many  (many),
		.z     (z),
		.x_out (mx),
		.y_out (my)
	);

	dhu_xform #(
		.COORD_BITS (COORD_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_xform (
		.clk (clk),
		.en  (en[DIV_LO-1:XF_LO]),
		.mat (mat_q),
		.z   (z),
		.x   (mx),
		.y   (my),
		.acc (acc)
	);

	for (genvar r = 0; r < 3; r++) begin : g_lane
		dhu_div #(
			.ACC_BITS (ACC_BITS)
		) u_div (
			.clk (clk),
			.en  (en[NUM_ST-1:DIV_LO]),
			.acc (acc[r]),
			.w   (acc[3]),
			.pos (pos[r])
		);
	end

	// zero the position unless a region was found
	assign region  = (kind_sp[NUM_ST-1] == KIND_REGION);
	assign kind    = kind_sp[NUM_ST-1];
	assign seen_id = sid_sp[NUM_ST-1];
	assign pos_x   = region ? $signed(pos[0]) : '0;
	assign pos_y   = region ? $signed(pos[1]) : '0;
	assign pos_z   = region ? $signed(pos[2]) : '0;

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_stall && (&vld_q)) |-> pix_stall)
		else $error("full pipeline took a pixel beat under stall");

	a_flow_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_stall |-> !pix_stall)
		else $error("pixel side stalled while result side is free");

	a_seen_id: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == KIND_SEEN)) |-> (seen_id != EMPTY_ID))
		else $error("seen result carries the empty id");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == KIND_NONE)) |-> (seen_id == '0))
		else $error("empty result carries an id");

endmodule
